// ===== hdl/smms_pkg.sv =====
`default_nettype none
package smms_pkg;

  localparam int FUNC_W   = 2;
  localparam int SEL_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int SIZE_W   = 11;
  localparam int STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_PEEK = 2'd2,
    FUNC_SIZE = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_RD_WAIT,
    S_MV_LOAD,
    S_MV_RUN,
    S_GROW_FIN
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/smms_req_if.sv =====
`default_nettype none
interface smms_req_if;
  logic                         valid;
  logic                         ready;
  logic [smms_pkg::FUNC_W-1:0]  func;
  logic [smms_pkg::SEL_W-1:0]   stack_sel;
  logic [smms_pkg::VALUE_W-1:0] value;

  modport source (output valid, output func, output stack_sel, output value, input ready);
  modport sink   (input valid, input func, input stack_sel, input value, output ready);
endinterface
`default_nettype wire

// ===== hdl/smms_rsp_if.sv =====
`default_nettype none
interface smms_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [smms_pkg::VALUE_W-1:0]  value_out;
  logic [smms_pkg::SIZE_W-1:0]   size_out;
  logic [smms_pkg::STATUS_W-1:0] status;

  modport source (output valid, output value_out, output size_out, output status, input ready);
  modport sink   (input valid, input value_out, input size_out, input status, output ready);
endinterface
`default_nettype wire

// ===== hdl/smms_ram.sv =====
`default_nettype none
module smms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/shared_memory_multi_stack.sv =====
`default_nettype none
// Several stacks in one element RAM. Stack s occupies a contiguous region whose
// base is the sum of the capacities of the stacks below it. One request at a
// time: a pop or peek that reads the RAM waits in S_RD_WAIT for the registered
// RAM read; every other request, including refused pushes and pops or peeks on
// an empty stack, is answered from S_DECIDE. A push onto a full stack doubles its
// capacity and first moves every higher stack up by the old capacity, through
// the single RAM port pair at one element per cycle.
// A result waiting in the output register does not block the next accept.
module shared_memory_multi_stack #(
  parameter int NUM_STACKS    = 3,
  parameter int INIT_CAPACITY = 4,
  parameter int MEM_DEPTH     = 1024,
  parameter int DATA_WIDTH    = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  smms_req_if.sink  req,
  smms_rsp_if.source rsp
);
  import smms_pkg::*;

  localparam int SIW  = $clog2(NUM_STACKS);
  localparam int AW   = $clog2(MEM_DEPTH);
  localparam int MAXV = (MEM_DEPTH > NUM_STACKS * INIT_CAPACITY) ?
                        MEM_DEPTH : NUM_STACKS * INIT_CAPACITY;
  localparam int SW   = $clog2(MAXV + 1);
  localparam logic [SW:0] DEPTH_L = (SW+1)'(MEM_DEPTH);

  state_t state, state_next;

  // captured request
  func_t                r_func;
  logic                 r_sel_ok;
  logic [SIW-1:0]       r_sel_idx;
  logic [VALUE_W-1:0]   r_value;

  // stack layout
  logic [SW-1:0] sizes [NUM_STACKS];
  logic [SW-1:0] caps  [NUM_STACKS];
  logic [SW-1:0] bases [NUM_STACKS];
  logic [SW-1:0] total;

  // relocation sequencer
  logic [SIW-1:0] mv_t;
  logic [SW-1:0]  mv_cnt;
  logic [SW-1:0]  mv_src;
  logic           mw_pend;
  logic [AW-1:0]  mw_addr;

  // output register
  logic               out_valid;
  logic [VALUE_W-1:0] out_value;
  logic [SIZE_W-1:0]  out_size;
  status_t            out_status;

  // RAM
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  // control from the sequencer
  logic           accept;
  logic           rsp_busy;
  logic           res_load;
  logic [VALUE_W-1:0] res_value;
  logic [SW-1:0]  res_size;
  status_t        res_status;
  logic           push_we;
  logic [AW-1:0]  push_addr;
  logic           size_inc, size_dec;
  logic           mv_start, mv_load, mv_step, mv_t_dec, grow_fin;

  logic [SIW-1:0] idx;
  logic           idx_ok;
  logic [SW-1:0]  cur_size, cur_cap, cur_base;
  logic [SW:0]    slot_push, slot_pop, grow_need, mv_dst;

  logic [SIW+1:0]            sel_ext;
  logic [DATA_WIDTH+VALUE_W-1:0] wr_ext, rd_ext;
  logic [SW+SIZE_W-1:0]      size_ext;

  assign sel_ext  = {{SIW{1'b0}}, req.stack_sel};
  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp_busy = out_valid && !rsp.ready;

  assign wr_ext   = {{DATA_WIDTH{1'b0}}, r_value};
  assign rd_ext   = {{VALUE_W{1'b0}}, ram_rdata};
  assign size_ext = {{SIZE_W{1'b0}}, res_size};

  // one stack selected at a time: the relocation target or the request's stack
  always_comb begin
    idx    = (state == S_MV_LOAD) ? mv_t : r_sel_idx;
    idx_ok = {1'b0, idx} < (SIW+1)'(NUM_STACKS);
    if (idx_ok) begin
      cur_size = sizes[idx];
      cur_cap  = caps[idx];
      cur_base = bases[idx];
    end else begin
      cur_size = '0;
      cur_cap  = '0;
      cur_base = '0;
    end
  end

  assign slot_push = {1'b0, cur_base} + {1'b0, cur_size};
  assign slot_pop  = slot_push - (SW+1)'(1);
  assign grow_need = {1'b0, total} + {1'b0, cur_cap};
  assign mv_dst    = {1'b0, mv_src} + {1'b0, cur_cap};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    res_load   = 1'b0;
    res_value  = '0;
    res_size   = '0;
    res_status = ST_OK;
    push_we    = 1'b0;
    push_addr  = slot_push[AW-1:0];
    ram_re     = 1'b0;
    ram_raddr  = slot_pop[AW-1:0];
    size_inc   = 1'b0;
    size_dec   = 1'b0;
    mv_start   = 1'b0;
    mv_load    = 1'b0;
    mv_step    = 1'b0;
    mv_t_dec   = 1'b0;
    grow_fin   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!rsp_busy) begin
          state_next = S_IDLE;
          if (!r_sel_ok) begin
            res_load = 1'b1;
            case (r_func)
              FUNC_PUSH: res_status = ST_FULL;
              FUNC_POP,
              FUNC_PEEK: res_status = ST_EMPTY;
              default:   res_status = ST_OK;
            endcase
          end else begin
            case (r_func)
              FUNC_PUSH: begin
                if (cur_size < cur_cap) begin
                  res_load = 1'b1;
                  if (slot_push < DEPTH_L) begin
                    push_we  = 1'b1;
                    size_inc = 1'b1;
                    res_size = cur_size + SW'(1);
                  end else begin
                    res_status = ST_FULL;
                    res_size   = cur_size;
                  end
                end else if (grow_need > DEPTH_L) begin
                  res_load   = 1'b1;
                  res_status = ST_FULL;
                  res_size   = cur_size;
                end else begin
                  mv_start   = 1'b1;
                  state_next = S_MV_LOAD;
                end
              end
              FUNC_POP,
              FUNC_PEEK: begin
                if (cur_size == '0) begin
                  res_load   = 1'b1;
                  res_status = ST_EMPTY;
                end else begin
                  size_dec = (r_func == FUNC_POP);
                  if (slot_pop < DEPTH_L) begin
                    ram_re     = 1'b1;
                    state_next = S_RD_WAIT;
                  end else begin
                    // slot beyond the RAM: element reads as zero
                    res_load = 1'b1;
                    res_size = (r_func == FUNC_POP) ? cur_size - SW'(1) : cur_size;
                  end
                end
              end
              default: begin
                res_load = 1'b1;
                res_size = cur_size;
              end
            endcase
          end
        end
      end
      S_RD_WAIT: begin
        res_load   = 1'b1;
        res_value  = rd_ext[VALUE_W-1:0];
        res_size   = cur_size;
        state_next = S_IDLE;
      end
      S_MV_LOAD: begin
        if (mv_t == r_sel_idx) begin
          state_next = S_GROW_FIN;
        end else begin
          mv_load    = 1'b1;
          state_next = S_MV_RUN;
        end
      end
      S_MV_RUN: begin
        ram_raddr = mv_src[AW-1:0];
        if (mv_cnt != '0) begin
          ram_re  = 1'b1;
          mv_step = 1'b1;
        end else begin
          mv_t_dec   = 1'b1;
          state_next = S_MV_LOAD;
        end
      end
      S_GROW_FIN: begin
        grow_fin   = 1'b1;
        state_next = S_DECIDE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      r_func    <= func_t'(req.func);
      r_sel_ok  <= sel_ext < (SIW+2)'(NUM_STACKS);
      r_sel_idx <= sel_ext[SIW-1:0];
      r_value   <= req.value;
    end
  end

  // layout registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_STACKS; s++) begin
        sizes[s] <= '0;
        caps[s]  <= SW'(INIT_CAPACITY);
        bases[s] <= SW'(s * INIT_CAPACITY);
      end
      total <= SW'(NUM_STACKS * INIT_CAPACITY);
    end else begin
      if (size_inc) begin
        sizes[r_sel_idx] <= cur_size + SW'(1);
      end else if (size_dec) begin
        sizes[r_sel_idx] <= cur_size - SW'(1);
      end
      if (grow_fin) begin
        caps[r_sel_idx] <= cur_cap << 1;
        total           <= total + cur_cap;
        for (int s = 0; s < NUM_STACKS; s++) begin
          if (SIW'(s) > r_sel_idx) begin
            bases[s] <= bases[s] + cur_cap;
          end
        end
      end
    end
  end

  // relocation: each stack above the grown one is copied top element first;
  // each write lands in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      mw_pend <= 1'b0;
    end else begin
      mw_pend <= mv_step;
    end
  end

  always_ff @(posedge clk) begin
    if (mv_start) begin
      mv_t <= SIW'(NUM_STACKS - 1);
    end else if (mv_t_dec) begin
      mv_t <= mv_t - SIW'(1);
    end
    if (mv_load) begin
      mv_cnt <= cur_size;
      mv_src <= slot_pop[SW-1:0];
    end else if (mv_step) begin
      mv_cnt <= mv_cnt - SW'(1);
      mv_src <= mv_src - SW'(1);
    end
    if (mv_step) begin
      mw_addr <= mv_dst[AW-1:0];
    end
  end

  assign ram_we    = push_we || mw_pend;
  assign ram_waddr = mw_pend ? mw_addr : push_addr;
  assign ram_wdata = mw_pend ? ram_rdata : wr_ext[DATA_WIDTH-1:0];

  smms_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_value  <= res_value;
      out_size   <= size_ext[SIZE_W-1:0];
      out_status <= res_status;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.value_out = out_value;
  assign rsp.size_out  = out_size;
  assign rsp.status    = out_status;

  for (genvar k = 0; k < NUM_STACKS; k++) begin : g_chk
    a_size_within_cap: assert property (@(posedge clk) disable iff (rst)
      sizes[k] <= caps[k])
      else $error("stack size above its capacity");
  end

  a_layout_total: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, bases[NUM_STACKS-1]} + {1'b0, caps[NUM_STACKS-1]}) == {1'b0, total})
    else $error("top stack end does not match total capacity");

  a_move_write_in_run: assert property (@(posedge clk) disable iff (rst)
    mw_pend |-> (state == S_MV_RUN) && !push_we)
    else $error("relocation write outside the copy loop");

  a_no_overwrite_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |-> !res_load)
    else $error("result loaded over one not yet taken");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import smms_pkg::*;

  localparam int NUM_STACKS    = 3;
  localparam int INIT_CAPACITY = 4;
  localparam int MEM_DEPTH     = 1024;
  localparam int DATA_WIDTH    = 32;

  localparam logic [SEL_W-1:0] INVALID_SEL = 2'd3;

  // longest correct gap: a growth moving nearly the whole memory, plus stalls
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [VALUE_W-1:0] value_out;
    logic [SIZE_W-1:0]  size_out;
    status_t            status;
  } stack_result_t;

  logic clk;
  logic rst;
  logic idle_on;

  smms_req_if req_ch ();
  smms_rsp_if rsp_ch ();

  shared_memory_multi_stack #(
    .NUM_STACKS    (NUM_STACKS),
    .INIT_CAPACITY (INIT_CAPACITY),
    .MEM_DEPTH     (MEM_DEPTH),
    .DATA_WIDTH    (DATA_WIDTH)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow of the stacks
  logic [DATA_WIDTH-1:0] shadow_mem [MEM_DEPTH];
  int unsigned           shadow_size [NUM_STACKS];
  int unsigned           shadow_cap  [NUM_STACKS];

  stack_result_t pending_results[$];
  int            err_count = 0;
  int            quiet_cycles = 0;
  int            stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned region_base(int unsigned s);
    int unsigned acc;
    acc = 0;
    for (int unsigned i = 0; i < s; i++) acc += shadow_cap[i];
    return acc;
  endfunction

  // double stack s, shifting every stack above it up by the old capacity
  function automatic bit grow_region(int unsigned s);
    int unsigned old_cap;
    int unsigned b;
    int unsigned n;
    old_cap = shadow_cap[s];
    if (region_base(NUM_STACKS) + old_cap > MEM_DEPTH) return 1'b0;
    for (int t = NUM_STACKS - 1; t > int'(s); t--) begin
      b = region_base(t);
      n = shadow_size[t];
      // top-down copy since source and destination overlap
      for (int k = int'(n) - 1; k >= 0; k--)
        shadow_mem[b + old_cap + k] = shadow_mem[b + k];
    end
    shadow_cap[s] = old_cap * 2;
    return 1'b1;
  endfunction

  function automatic stack_result_t apply_stack_op(func_t f, logic [SEL_W-1:0] sel,
                                                   logic [VALUE_W-1:0] val);
    stack_result_t r;
    int unsigned   slot;
    bit            fits;
    r.value_out = '0;
    r.size_out  = '0;
    r.status    = ST_OK;
    if (sel >= NUM_STACKS) begin
      if (f == FUNC_PUSH) r.status = ST_FULL;
      else if (f != FUNC_SIZE) r.status = ST_EMPTY;
      return r;
    end
    case (f)
      FUNC_PUSH: begin
        fits = 1'b1;
        if (shadow_size[sel] >= shadow_cap[sel]) fits = grow_region(sel);
        if (fits) begin
          slot = region_base(sel) + shadow_size[sel];
          if (slot < MEM_DEPTH) begin
            shadow_mem[slot] = val[DATA_WIDTH-1:0];
            shadow_size[sel]++;
          end else begin
            fits = 1'b0;
          end
        end
        if (!fits) r.status = ST_FULL;
      end
      FUNC_POP, FUNC_PEEK: begin
        if (shadow_size[sel] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot = region_base(sel) + shadow_size[sel] - 1;
          if (slot < MEM_DEPTH) r.value_out = VALUE_W'(shadow_mem[slot]);
          if (f == FUNC_POP) shadow_size[sel]--;
        end
      end
      default: ;
    endcase
    r.size_out = SIZE_W'(shadow_size[sel]);
    return r;
  endfunction

  // predict on every accepted request
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      pending_results.push_back(apply_stack_op(func_t'(req_ch.func), req_ch.stack_sel,
                                               req_ch.value));
  end

  always @(posedge clk) begin
    stack_result_t got;
    stack_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.value_out = rsp_ch.value_out;
      got.size_out  = rsp_ch.size_out;
      got.status    = status_t'(rsp_ch.status);
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: result with none expected: value_out=%h size_out=%0d status=%0d",
                 $time, got.value_out, got.size_out, got.status);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count < 100)
            $display("%0t: mismatch: expected value_out=%h size_out=%0d status=%0d, got value_out=%h size_out=%0d status=%0d",
                     $time, want.value_out, want.size_out, want.status,
                     got.value_out, got.size_out, got.status);
        end
      end
    end
  end

  // result side back-pressure in short bursts
  always @(posedge clk) begin
    if (!idle_on) begin
      rsp_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[shared_memory_multi_stack] ERROR");
        $finish;
      end
    end
  end

  task automatic send_request(input func_t f, input logic [SEL_W-1:0] sel,
                              input logic [VALUE_W-1:0] val);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.func      <= f;
    req_ch.stack_sel <= sel;
    req_ch.value     <= val;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  function automatic logic [VALUE_W-1:0] random_element();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int push_pct, input int pop_pct, input int peek_pct,
                             input int hot_stack, input int hot_pct);
    int               pick;
    func_t            f;
    logic [SEL_W-1:0] sel;
    pick = $urandom_range(0, 99);
    if (pick < push_pct) f = FUNC_PUSH;
    else if (pick < push_pct + pop_pct) f = FUNC_POP;
    else if (pick < push_pct + pop_pct + peek_pct) f = FUNC_PEEK;
    else f = FUNC_SIZE;
    if ($urandom_range(0, 19) == 0) sel = INVALID_SEL;
    else if ($urandom_range(0, 99) < hot_pct) sel = SEL_W'(hot_stack);
    else sel = SEL_W'($urandom_range(0, NUM_STACKS - 1));
    send_request(f, sel, random_element());
  endtask

  task automatic test_empty_and_invalid();
    send_request(FUNC_SIZE, 2'd0, 32'h0);
    send_request(FUNC_SIZE, INVALID_SEL, 32'h0);
    send_request(FUNC_POP, 2'd0, 32'h0);
    send_request(FUNC_PEEK, 2'd2, 32'h0);
    send_request(FUNC_PUSH, INVALID_SEL, 32'hFFFF_FFFF);
    send_request(FUNC_POP, INVALID_SEL, 32'h0);
    send_request(FUNC_PEEK, INVALID_SEL, 32'h0);
  endtask

  task automatic test_push_extremes();
    send_request(FUNC_PUSH, 2'd2, 32'h7FFF_FFFF);
    send_request(FUNC_PUSH, 2'd2, 32'h8000_0000);
    send_request(FUNC_PUSH, 2'd1, 32'h0000_0000);
    send_request(FUNC_PUSH, 2'd1, 32'hFFFF_FFFF);
    send_request(FUNC_PUSH, 2'd1, 32'h5555_5555);
    send_request(FUNC_PUSH, 2'd1, 32'hAAAA_AAAA);
  endtask

  // fifth push into stack 1 doubles it and relocates stack 2
  task automatic test_growth_moves();
    send_request(FUNC_PUSH, 2'd1, 32'h0000_0001);
    send_request(FUNC_PEEK, 2'd2, 32'h0);
    send_request(FUNC_POP, 2'd2, 32'h0);
    send_request(FUNC_POP, 2'd1, 32'h0);
    send_request(FUNC_PEEK, 2'd1, 32'h0);
    send_request(FUNC_SIZE, 2'd1, 32'h0);
    send_request(FUNC_POP, 2'd2, 32'h0);
    send_request(FUNC_POP, 2'd2, 32'h0);
    send_request(FUNC_SIZE, 2'd2, 32'h0);
  endtask

  task automatic test_mixed_traffic();
    for (int i = 0; i < 300; i++) send_random(40, 25, 20, 0, 0);
  endtask

  // push-heavy on the lowest stack: many relocations, then refusals once memory is full
  task automatic test_fill_to_full();
    for (int i = 0; i < 900; i++) send_random(85, 5, 5, 0, 80);
  endtask

  task automatic test_drain();
    for (int i = 0; i < 500; i++) send_random(15, 60, 15, $urandom_range(0, 2), 50);
  endtask

  task automatic test_back_to_back();
    idle_on <= 1'b0;
    for (int i = 0; i < 200; i++) send_random(40, 30, 20, 0, 0);
  endtask

  initial begin
    rst              = 1'b1;
    idle_on          = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.func      = FUNC_SIZE;
    req_ch.stack_sel = '0;
    req_ch.value     = '0;
    rsp_ch.ready     = 1'b0;
    for (int i = 0; i < NUM_STACKS; i++) begin
      shadow_size[i] = 0;
      shadow_cap[i]  = INIT_CAPACITY;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_invalid();
    test_push_extremes();
    test_growth_moves();
    test_mixed_traffic();
    test_fill_to_full();
    test_drain();
    test_back_to_back();

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[shared_memory_multi_stack] OK");
    end else begin
      $display("[shared_memory_multi_stack] ERROR");
    end
    $finish;
  end

endmodule
